/* src/wfsa_pkg.sv */
// Types and constants shared by the worst-fit segment allocator modules.
package wfsa_pkg;

  localparam int POOL_MAX     = 65536;
  localparam int MAX_SEGMENTS = 64;
  localparam int MAX_REQUESTS = 1024;

  localparam int ADDR_W    = 17;
  localparam int SIZE_W    = 17;
  localparam int TARGET_W  = 11;
  localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
  localparam int HND_W     = $clog2(MAX_REQUESTS);
  localparam int CNT_W     = HND_W + 1;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [SEG_IDX_W-1:0] seg_idx_t;
  typedef logic [HND_W-1:0]     hnd_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [2:0] {
    STAT_GRANTED = 3'd0,
    STAT_REFUSED = 3'd1,
    STAT_FREED   = 3'd2,
    STAT_IGNORED = 3'd3,
    STAT_FULL    = 3'd4
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [SIZE_W-1:0]   alloc_size;
    logic [TARGET_W-1:0] free_target;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] start_address;
  } out_word_t;

  // search word passed from cell to cell
  typedef struct packed {
    logic     vld;
    addr_t    hs;
    addr_t    he;
    logic     best_f;
    seg_idx_t best_idx;
    addr_t    best_start;
    addr_t    best_len;
    logic     left_f;
    seg_idx_t left_idx;
    addr_t    left_start;
    addr_t    left_len;
    logic     right_f;
    seg_idx_t right_idx;
    addr_t    right_len;
    logic     empty_f;
    seg_idx_t empty_idx;
  } scan_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic     init;
    addr_t    init_len;
    logic     wr_en;
    seg_idx_t wr_idx;
    addr_t    wr_start;
    addr_t    wr_len;
    logic     kill_en;
    seg_idx_t kill_idx;
  } cmd_t;

  typedef struct packed {
    logic  live;
    addr_t start;
    addr_t len;
  } hnd_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } state_t;

endpackage

/* src/wfsa_cell.sv */
// One free-segment table entry with its stage of the search chain.
module wfsa_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  wfsa_pkg::seg_idx_t cell_idx,
  input  wfsa_pkg::cmd_t    cmd,
  input  wfsa_pkg::scan_t   word_in,
  output wfsa_pkg::scan_t   word_out
);
  import wfsa_pkg::*;

  logic  valid_r, valid_nxt;
  addr_t start_r, start_nxt;
  addr_t len_r, len_nxt;
  scan_t word_r, word_nxt;
  logic [ADDR_W:0] seg_end;

  assign seg_end = {1'b0, start_r} + {1'b0, len_r};

  always_comb begin
    valid_nxt = valid_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    if (cmd.init) begin
      valid_nxt = (cell_idx == '0);
      start_nxt = addr_t'(1);
      len_nxt   = cmd.init_len;
    end else begin
      if (cmd.wr_en && cmd.wr_idx == cell_idx) begin
        valid_nxt = 1'b1;
        start_nxt = cmd.wr_start;
        len_nxt   = cmd.wr_len;
      end
      if (cmd.kill_en && cmd.kill_idx == cell_idx) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    word_nxt = word_in;
    if (valid_r) begin
      if (!word_in.best_f || len_r > word_in.best_len ||
          (len_r == word_in.best_len && start_r < word_in.best_start)) begin
        word_nxt.best_f     = 1'b1;
        word_nxt.best_idx   = cell_idx;
        word_nxt.best_start = start_r;
        word_nxt.best_len   = len_r;
      end
      if (seg_end == {1'b0, word_in.hs}) begin
        word_nxt.left_f     = 1'b1;
        word_nxt.left_idx   = cell_idx;
        word_nxt.left_start = start_r;
        word_nxt.left_len   = len_r;
      end
      if (start_r == word_in.he) begin
        word_nxt.right_f   = 1'b1;
        word_nxt.right_idx = cell_idx;
        word_nxt.right_len = len_r;
      end
    end else if (!word_in.empty_f) begin
      word_nxt.empty_f   = 1'b1;
      word_nxt.empty_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= (cell_idx == '0);
      start_r    <= addr_t'(1);
      len_r      <= addr_t'(POOL_MAX);
      word_r     <= '0;
    end else begin
      valid_r    <= valid_nxt;
      start_r    <= start_nxt;
      len_r      <= len_nxt;
      word_r     <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

/* src/wfsa_ctrl.sv */
// Request sequencer, handle memory and result register of the allocator.
module wfsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wfsa_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wfsa_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  wfsa_pkg::addr_t    cfg_data,
  output wfsa_pkg::scan_t    scan_in,
  input  wfsa_pkg::scan_t    scan_out,
  output wfsa_pkg::cmd_t     cmd
);
  import wfsa_pkg::*;

  hnd_entry_t hmem [MAX_REQUESTS];
  hnd_entry_t rd_q_r;

  state_t     state_r, state_nxt;
  cnt_t       req_cnt_r, req_cnt_nxt;
  logic       clr_busy_r, clr_busy_nxt;
  hnd_t       clr_cnt_r, clr_cnt_nxt;
  logic       op_r, op_nxt;
  addr_t      size_r, size_nxt;
  hnd_t       hnd_r, hnd_nxt;
  addr_t      hs_r, hs_nxt;
  addr_t      hl_r, hl_nxt;
  scan_t      res_r, res_nxt;
  status_t    stat_r, stat_nxt;
  addr_t      addr_r, addr_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;

  logic       accept;
  logic       mem_we;
  hnd_t       mem_wa;
  hnd_entry_t mem_wd;
  logic       mem_re;
  hnd_t       mem_ra;
  logic [CNT_W:0] tgt_m1;
  addr_t      pool_clamped;

  assign accept    = in_valid && in_ready;
  assign tgt_m1    = (CNT_W + 1)'(in_data.free_target) - (CNT_W + 1)'(1);
  assign mem_re    = accept && in_data.opcode == OP_FREE;
  assign mem_ra    = tgt_m1[HND_W-1:0];

  always_comb begin
    if (cfg_data == '0) begin
      pool_clamped = addr_t'(1);
    end else if ({1'b0, cfg_data} > (ADDR_W + 1)'(POOL_MAX)) begin
      pool_clamped = addr_t'(POOL_MAX);
    end else begin
      pool_clamped = cfg_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_cnt_nxt   = req_cnt_r;
    clr_busy_nxt  = clr_busy_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    size_nxt      = size_r;
    hnd_nxt       = hnd_r;
    hs_nxt        = hs_r;
    hl_nxt        = hl_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    scan_in       = '0;
    cmd           = '0;
    mem_we        = 1'b0;
    mem_wa        = clr_cnt_r;
    mem_wd        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (clr_busy_r) begin
      mem_we      = 1'b1;
      clr_cnt_nxt = clr_cnt_r + hnd_t'(1);
      if (clr_cnt_r == hnd_t'(MAX_REQUESTS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    if (cfg_we) begin
      cmd.init     = 1'b1;
      cmd.init_len = pool_clamped;
      clr_busy_nxt = 1'b1;
      clr_cnt_nxt  = '0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = !clr_busy_r && !cfg_we;
        if (accept) begin
          op_nxt   = in_data.opcode;
          size_nxt = in_data.alloc_size;
          addr_nxt = '0;
          if (in_data.opcode == OP_ALLOC) begin
            if (req_cnt_r >= cnt_t'(MAX_REQUESTS)) begin
              stat_nxt  = STAT_REFUSED;
              state_nxt = ST_OUT;
            end else begin
              hnd_nxt     = req_cnt_r[HND_W-1:0];
              req_cnt_nxt = req_cnt_r + cnt_t'(1);
              if (in_data.alloc_size == '0) begin
                stat_nxt  = STAT_REFUSED;
                state_nxt = ST_OUT;
              end else begin
                scan_in.vld = 1'b1;
                state_nxt   = ST_SCAN;
              end
            end
          end else begin
            hnd_nxt = tgt_m1[HND_W-1:0];
            if (req_cnt_r < cnt_t'(MAX_REQUESTS)) begin
              req_cnt_nxt = req_cnt_r + cnt_t'(1);
            end
            if (in_data.free_target == '0 || tgt_m1 >= {1'b0, req_cnt_r}) begin
              stat_nxt  = STAT_IGNORED;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        if (!rd_q_r.live) begin
          stat_nxt  = STAT_IGNORED;
          state_nxt = ST_OUT;
        end else begin
          hs_nxt      = rd_q_r.start;
          hl_nxt      = rd_q_r.len;
          scan_in.vld = 1'b1;
          scan_in.hs  = rd_q_r.start;
          scan_in.he  = rd_q_r.start + rd_q_r.len;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_out.vld) begin
          res_nxt   = scan_out;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_OUT;
        mem_wa    = hnd_r;
        if (op_r == OP_ALLOC) begin
          if (res_r.best_f && res_r.best_len >= size_r) begin
            stat_nxt = STAT_GRANTED;
            addr_nxt = res_r.best_start;
            if (res_r.best_len == size_r) begin
              cmd.kill_en  = 1'b1;
              cmd.kill_idx = res_r.best_idx;
            end else begin
              cmd.wr_en    = 1'b1;
              cmd.wr_idx   = res_r.best_idx;
              cmd.wr_start = res_r.best_start + size_r;
              cmd.wr_len   = res_r.best_len - size_r;
            end
            mem_we       = 1'b1;
            mem_wd.live  = 1'b1;
            mem_wd.start = res_r.best_start;
            mem_wd.len   = size_r;
          end else begin
            stat_nxt = STAT_REFUSED;
          end
        end else begin
          stat_nxt = STAT_FREED;
          mem_we   = 1'b1;
          priority if (res_r.left_f && res_r.right_f) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_idx   = res_r.left_idx;
            cmd.wr_start = res_r.left_start;
            cmd.wr_len   = res_r.left_len + hl_r + res_r.right_len;
            cmd.kill_en  = 1'b1;
            cmd.kill_idx = res_r.right_idx;
          end else if (res_r.left_f) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_idx   = res_r.left_idx;
            cmd.wr_start = res_r.left_start;
            cmd.wr_len   = res_r.left_len + hl_r;
          end else if (res_r.right_f) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_idx   = res_r.right_idx;
            cmd.wr_start = hs_r;
            cmd.wr_len   = res_r.right_len + hl_r;
          end else if (res_r.empty_f) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_idx   = res_r.empty_idx;
            cmd.wr_start = hs_r;
            cmd.wr_len   = hl_r;
          end else begin
            stat_nxt = STAT_FULL;
            mem_we   = 1'b0;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = stat_r;
          out_data_nxt.start_address = addr_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hmem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= hmem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_cnt_r   <= '0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_cnt_r   <= req_cnt_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    size_r     <= size_nxt;
    hnd_r      <= hnd_nxt;
    hs_r       <= hs_nxt;
    hl_r       <= hl_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("item taken during handle clear");

  a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_out.vld |-> state_r == ST_SCAN)
    else $error("search word arrived outside scan");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    req_cnt_r <= cnt_t'(MAX_REQUESTS))
    else $error("request counter overrun");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && stat_r == STAT_GRANTED) |-> addr_r != '0)
    else $error("granted block with zero start");

endmodule

/* src/worst_fit_segment_allocator.sv */
// Top level of the worst-fit segment allocator: sequencer plus chain of table cells.
//
// Input words (in_valid/in_ready) carry an allocate or a free request; each
// request yields exactly one result word on out_valid/out_ready: a status and,
// for a grant, the first cell of the block. Every request takes a sequence
// number from 1; a free names an earlier number.
// The free-segment table sits in a row of MAX_SEGMENTS cells. A search word
// enters the first cell and moves one cell per cycle through the whole chain.
// An allocate goes from idle to the scan, then to the table update and the
// result register; a free first reads its handle and then does the same.
// Refusals and ignored frees that need no search go straight to the result
// register. One request is in flight at a time.
// The result register lets a finished word wait for out_ready while the
// block returns to idle; a following result waits until the first is taken.
// After reset, and after every cfg_we write of the pool size, the handle memory
// is cleared one entry a cycle, with in_ready low until all MAX_REQUESTS (1024)
// entries are clear. A pool size write also rebuilds the table as one segment.
module worst_fit_segment_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wfsa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wfsa_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  wfsa_pkg::addr_t     cfg_data
);
  import wfsa_pkg::*;

  scan_t chain [MAX_SEGMENTS+1];
  cmd_t  cmd;

  wfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .scan_in   (chain[0]),
    .scan_out  (chain[MAX_SEGMENTS]),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    wfsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (seg_idx_t'(i)),
      .cmd      (cmd),
      .word_in  (chain[i]),
      .word_out (chain[i+1])
    );
  end

endmodule

/* verif/tb_worst_fit_segment_allocator.sv */
// Testbench for the worst-fit segment allocator: directed table, a fragmentation run, then random phases
`timescale 1ns / 100ps

module tb_worst_fit_segment_allocator;
  import wfsa_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  addr_t     cfg_data;

  worst_fit_segment_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // shadow of the allocator state
  addr_t     seg_start [MAX_SEGMENTS];
  addr_t     seg_len   [MAX_SEGMENTS];
  bit        seg_vld   [MAX_SEGMENTS];
  addr_t     hnd_start [MAX_REQUESTS];
  addr_t     hnd_len   [MAX_REQUESTS];
  bit        hnd_live  [MAX_REQUESTS];
  int        seq_count;
  int        pool_cells;
  int        granted_seq[$];
  out_word_t pending_words[$];
  int        err_count;
  bit        quiet;

  function automatic void rebuild_pool(int value);
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_start[i] = '0;
      seg_len[i]   = '0;
      seg_vld[i]   = 1'b0;
    end
    for (int i = 0; i < MAX_REQUESTS; i++) hnd_live[i] = 1'b0;
    pool_cells   = (value == 0) ? 1 : (value > POOL_MAX) ? POOL_MAX : value;
    seg_start[0] = addr_t'(1);
    seg_len[0]   = addr_t'(pool_cells);
    seg_vld[0]   = 1'b1;
    granted_seq.delete();
  endfunction

  function automatic out_word_t allocator_result(in_word_t w);
    out_word_t r;
    int        best, left, right, empty, num;
    addr_t     hs, hl;
    bit        known;
    r.status        = STAT_REFUSED;
    r.start_address = '0;
    if (w.opcode == OP_ALLOC) begin
      if (seq_count < MAX_REQUESTS) begin
        num = seq_count;
        seq_count++;
        hnd_live[num] = 1'b0;
        if (w.alloc_size != 0) begin
          best = -1;
          for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (!seg_vld[i]) continue;
            if (best < 0 || seg_len[i] > seg_len[best] ||
                (seg_len[i] == seg_len[best] && seg_start[i] < seg_start[best]))
              best = i;
          end
          if (best >= 0 && seg_len[best] >= w.alloc_size) begin
            r.status        = STAT_GRANTED;
            r.start_address = seg_start[best];
            if (seg_len[best] == w.alloc_size) seg_vld[best] = 1'b0;
            else begin
              seg_start[best] += w.alloc_size;
              seg_len[best]   -= w.alloc_size;
            end
            hnd_start[num] = r.start_address;
            hnd_len[num]   = w.alloc_size;
            hnd_live[num]  = 1'b1;
            granted_seq.insert(granted_seq.size(), num + 1);
          end
        end
      end
    end else begin
      known = w.free_target >= 1 && (w.free_target - 1) < seq_count;
      if (seq_count < MAX_REQUESTS) seq_count++;
      r.status = STAT_IGNORED;
      if (known && hnd_live[w.free_target - 1]) begin
        num   = int'(w.free_target) - 1;
        hs    = hnd_start[num];
        hl    = hnd_len[num];
        left  = -1;
        right = -1;
        empty = -1;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
          if (!seg_vld[i]) begin
            if (empty < 0) empty = i;
            continue;
          end
          if (seg_start[i] + seg_len[i] == hs) left = i;
          if (seg_start[i] == hs + hl) right = i;
        end
        r.status = STAT_FREED;
        if (left >= 0 && right >= 0) begin
          seg_len[left] += hl + seg_len[right];
          seg_vld[right] = 1'b0;
        end else if (left >= 0) begin
          seg_len[left] += hl;
        end else if (right >= 0) begin
          seg_start[right] = hs;
          seg_len[right]  += hl;
        end else if (empty < 0) begin
          r.status = STAT_FULL;
        end else begin
          seg_start[empty] = hs;
          seg_len[empty]   = hl;
          seg_vld[empty]   = 1'b1;
        end
        if (r.status == STAT_FREED) hnd_live[num] = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // expected words come from the shadow, or from the directed table's typed word, when the word is accepted
  bit        use_typed;
  out_word_t typed_word;

  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t pred_w;
    if (rst_n && in_valid && in_ready) begin
      pred_w = allocator_result(in_data);
      pending_words.insert(pending_words.size(), use_typed ? typed_word : pred_w);
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) report("unexpected word", out_data.status, -1);
      else begin
        exp_w = pending_words.pop_front();
        if (out_data.status != exp_w.status)
          report("status", out_data.status, exp_w.status);
        if (out_data.start_address != exp_w.start_address)
          report("start_address", out_data.start_address, exp_w.start_address);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet) begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                             : $urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  task automatic send(in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool(int value);
    drain();
    repeat (80) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= addr_t'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    rebuild_pool(value);
  endtask

  function automatic in_word_t make_word(logic op, int size, int tgt);
    in_word_t w;
    w.opcode      = op;
    w.alloc_size  = SIZE_W'(size);
    w.free_target = TARGET_W'(tgt);
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    w.alloc_size  = SIZE_W'($urandom_range(0, 17'h1FFFF));
    w.free_target = TARGET_W'($urandom_range(0, 11'h7FF));
    r = $urandom_range(0, 99);
    w.opcode = (r < 55) ? OP_ALLOC : OP_FREE;
    if (w.opcode == OP_ALLOC) begin
      r = $urandom_range(0, 99);
      if (r < 80) w.alloc_size = SIZE_W'($urandom_range(1, pool_cells / 4 + 1));
      else if (r < 85) w.alloc_size = '0;
      else if (r < 90) w.alloc_size = SIZE_W'(pool_cells);
    end else if (granted_seq.size() != 0 && $urandom_range(0, 99) < 85) begin
      w.free_target = TARGET_W'(granted_seq[$urandom_range(0, granted_seq.size() - 1)]);
    end
    return w;
  endfunction

  typedef struct {
    logic    op;
    int      size;
    int      tgt;
    bit      typed;
    status_t st;
    int      addr;
  } row_t;

  row_t rows[24] = '{
    '{OP_ALLOC, 1,      0,    1, STAT_GRANTED, 1},
    '{OP_ALLOC, 0,      0,    1, STAT_REFUSED, 0},
    '{OP_ALLOC, 65536,  0,    1, STAT_REFUSED, 0},
    '{OP_ALLOC, 65535,  0,    1, STAT_GRANTED, 2},
    '{OP_ALLOC, 1,      0,    1, STAT_REFUSED, 0},
    '{OP_ALLOC, 131071, 2047, 1, STAT_REFUSED, 0},
    '{OP_FREE,  131071, 0,    1, STAT_IGNORED, 0},
    '{OP_FREE,  0,      2047, 1, STAT_IGNORED, 0},
    '{OP_FREE,  0,      9,    1, STAT_IGNORED, 0},
    '{OP_FREE,  0,      2,    1, STAT_IGNORED, 0},
    '{OP_FREE,  0,      7,    1, STAT_IGNORED, 0},
    '{OP_FREE,  0,      1,    1, STAT_FREED,   0},
    '{OP_FREE,  0,      1,    1, STAT_IGNORED, 0},
    '{OP_FREE,  0,      4,    1, STAT_FREED,   0},
    '{OP_ALLOC, 65536,  0,    1, STAT_GRANTED, 1},
    '{OP_FREE,  0,      15,   1, STAT_FREED,   0},
    '{OP_ALLOC, 10,     0,    0, STAT_GRANTED, 0},
    '{OP_ALLOC, 10,     0,    0, STAT_GRANTED, 0},
    '{OP_ALLOC, 10,     0,    0, STAT_GRANTED, 0},
    '{OP_FREE,  0,      17,   0, STAT_GRANTED, 0},
    '{OP_FREE,  0,      19,   0, STAT_GRANTED, 0},
    '{OP_FREE,  0,      18,   0, STAT_GRANTED, 0},
    '{OP_ALLOC, 65536,  0,    0, STAT_GRANTED, 0},
    '{OP_FREE,  0,      23,   0, STAT_GRANTED, 0}
  };

  int pools[8] = '{0, 131071, 7, 1000, 1, 65536, 100, 3000};

  initial begin
    int base;
    int holes[$];
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    err_count  = 0;
    quiet      = 0;
    use_typed  = 0;
    typed_word = '0;
    seq_count  = 0;
    rebuild_pool(65536);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      use_typed                <= rows[i].typed;
      typed_word.status        <= rows[i].st;
      typed_word.start_address <= addr_t'(rows[i].addr);
      send(make_word(rows[i].op, rows[i].size, rows[i].tgt));
    end
    drain();
    use_typed <= 1'b0;

    // fragment a small pool until the segment table overflows
    write_pool(200);
    base = seq_count;
    repeat (130) send(make_word(OP_ALLOC, 1, $urandom_range(0, 2047)));
    for (int k = 1; k <= 130; k += 2) send(make_word(OP_FREE, 0, base + k));
    for (int k = 2; k <= 130; k += 2) holes.insert(holes.size(), base + k);
    holes.shuffle();
    foreach (holes[k]) send(make_word(OP_FREE, $urandom_range(0, 17'h1FFFF), holes[k]));
    send(make_word(OP_FREE, 0, base + 129));

    foreach (pools[p]) begin
      write_pool(pools[p]);
      quiet = (p == 3);
      for (int k = 0; k < 108; k++) begin
        if (k == 54) drain();
        send(random_word());
      end
    end
    quiet = 0;

    drain();
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
